// File: design/rbf_pkg.sv
// Package for the ray versus box face intersection core.
// Holds field widths, face codes, the transaction structs and face lookup functions.
// Depends on nothing.
package rbf_pkg;

  localparam int COORD_W = 32;
  localparam int EXT_W   = 31;
  localparam int EPS_W   = 16;
  localparam int FRAC_W  = 16;
  localparam int BND_W   = COORD_W + 1;
  localparam int NUM_W   = COORD_W + 2;
  localparam int MAG_W   = NUM_W - 1;
  localparam int DVD_W   = MAG_W + FRAC_W;
  localparam int DEN_W   = COORD_W;
  localparam int TSPLIT  = 25;
  localparam int PROD_W  = DVD_W + DEN_W;
  localparam int R_W     = 49;
  localparam int PT_W    = 50;
  localparam int NF      = 5;
  localparam int FACE_W  = 3;

  localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;

  localparam logic [FACE_W-1:0] FACE_TOP   = 3'd0;
  localparam logic [FACE_W-1:0] FACE_FRONT = 3'd1;
  localparam logic [FACE_W-1:0] FACE_BACK  = 3'd2;
  localparam logic [FACE_W-1:0] FACE_LEFT  = 3'd3;
  localparam logic [FACE_W-1:0] FACE_RIGHT = 3'd4;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] ray_origin_x;
    logic signed [COORD_W-1:0] ray_origin_y;
    logic signed [COORD_W-1:0] ray_origin_z;
    logic signed [COORD_W-1:0] ray_dir_x;
    logic signed [COORD_W-1:0] ray_dir_y;
    logic signed [COORD_W-1:0] ray_dir_z;
    logic signed [COORD_W-1:0] box_origin_x;
    logic signed [COORD_W-1:0] box_origin_y;
    logic signed [COORD_W-1:0] box_origin_z;
    logic [EXT_W-1:0]          box_width;
    logic [EXT_W-1:0]          box_height;
    logic [EXT_W-1:0]          box_depth;
  } in_t;

  typedef struct packed {
    logic                      hit;
    logic [FACE_W-1:0]         hit_face;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } out_t;

  function automatic logic [1:0] face_axis(input logic [FACE_W-1:0] f);
    logic [1:0] ax;
    case (f)
      FACE_TOP:              ax = AXIS_Y;
      FACE_FRONT, FACE_BACK: ax = AXIS_Z;
      default:               ax = AXIS_X;
    endcase
    return ax;
  endfunction

  function automatic logic face_on_hi(input logic [FACE_W-1:0] f);
    logic hi;
    case (f)
      FACE_TOP, FACE_FRONT, FACE_RIGHT: hi = 1'b1;
      default:                          hi = 1'b0;
    endcase
    return hi;
  endfunction

endpackage

// File: design/ray_box_face_intersection_core.sv
// Ray versus axis-aligned box, five-face test in signed Q16.16, fully pipelined.
// One transaction per cycle while busy is low; busy is set by reset and cleared once it ends.
// A result passes a_r, s1, the 49-stage dividers, s2, m1 to m5, t1 to t3 and the output register.
// Reset is synchronous and active low; it clears all valid bits and sets epsilon to 7.
// The receiver cannot stall, so results leave on a fixed schedule.
// Depends on rbf_pkg and rbf_div.
module ray_box_face_intersection_core import rbf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_data,
  output logic             out_valid,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [EPS_W-1:0] cfg_wdata
);

  typedef struct packed {
    logic [NF-1:0]               ok;
    logic [NF-1:0]               tneg;
    logic [2:0]                  dneg;
    logic [2:0][DEN_W-1:0]       dmag;
    logic [2:0][COORD_W-1:0]     org;
    logic [2:0][BND_W-1:0]       lo;
    logic [2:0][BND_W-1:0]       hi;
  } side_t;

  typedef struct packed {
    logic                    ok;
    logic [FACE_W-1:0]       face;
    logic [DVD_W-1:0]        tmag;
    logic [2:0][PT_W-1:0]    pt;
  } cand_t;

  localparam logic [PROD_W:0] PROD_LIMIT = {{(PROD_W-62){1'b0}}, 1'b1, {62{1'b0}}};
  localparam logic [R_W-1:0]  FAR_R      = {1'b1, {(R_W-1){1'b0}}};

  function automatic cand_t pick(input cand_t a, input cand_t b);
    if (a.ok && (!b.ok || a.tmag <= b.tmag)) return a;
    return b;
  endfunction

  function automatic logic [COORD_W-1:0] sat(input logic [PT_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (&v[PT_W-1:COORD_W-1] || ~|v[PT_W-1:COORD_W-1]) r = v[COORD_W-1:0];
    else if (v[PT_W-1]) r = {1'b1, {(COORD_W-1){1'b0}}};
    else r = {1'b0, {(COORD_W-1){1'b1}}};
    return r;
  endfunction

  logic [EPS_W-1:0] eps_r;
  logic             busy_r;

  logic a_vld_r;
  in_t  a_r;

  logic                         s1_vld_r;
  side_t                        s1_side_r;
  logic [NF-1:0][DVD_W-1:0]     s1_dvd_r;
  logic [NF-1:0][DEN_W-1:0]     s1_den_r;

  logic [NF-1:0][DVD_W-1:0]     quot;
  logic [DVD_W-1:0]             dl_vld_r;
  side_t                        dl_side_r [DVD_W];

  logic                         s2_vld_r;
  side_t                        s2_side_r;
  logic [NF-1:0][DVD_W-1:0]     s2_tmag_r;

  logic                                          m1_vld_r;
  side_t                                         m1_side_r;
  logic [NF-1:0][DVD_W-1:0]                      m1_tmag_r;
  logic [NF-1:0][2:0][TSPLIT+DEN_W-1:0]          m1_lo_r;
  logic [NF-1:0][2:0][DVD_W-TSPLIT+DEN_W-1:0]    m1_hi_r;

  logic                             m2_vld_r;
  side_t                            m2_side_r;
  logic [NF-1:0][DVD_W-1:0]         m2_tmag_r;
  logic [NF-1:0][2:0][PROD_W-1:0]   m2_prod_r;

  logic                             m3_vld_r;
  side_t                            m3_side_r;
  logic [NF-1:0][DVD_W-1:0]         m3_tmag_r;
  logic [NF-1:0][2:0][R_W-1:0]      m3_mag_r;

  logic                             m4_vld_r;
  side_t                            m4_side_r;
  logic [NF-1:0][DVD_W-1:0]         m4_tmag_r;
  logic [NF-1:0][2:0][PT_W-1:0]     m4_pt_r;

  logic  m5_vld_r;
  cand_t m5_cand_r [NF];
  logic  t1_vld_r;
  cand_t t1_cand_r [3];
  logic  t2_vld_r;
  cand_t t2_cand_r [2];
  logic  t3_vld_r;
  cand_t t3_cand_r;

  logic out_vld_r;
  out_t out_r;

  // Stage 1 combinational: planes, numerators and divisor magnitudes.
  logic [BND_W-1:0]         lo_c [3];
  logic [BND_W-1:0]         hi_c [3];
  logic [COORD_W-1:0]       org_c [3];
  logic [COORD_W-1:0]       dir_c [3];
  logic [DEN_W-1:0]         cmag_c [3];
  side_t                    s1_side_nxt;
  logic [NF-1:0][DVD_W-1:0] s1_dvd_nxt;
  logic [NF-1:0][DEN_W-1:0] s1_den_nxt;

  always_comb begin
    logic [1:0]       ax;
    logic [BND_W-1:0] plane;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] nmag;
    org_c[0] = a_r.ray_origin_x;
    org_c[1] = a_r.ray_origin_y;
    org_c[2] = a_r.ray_origin_z;
    dir_c[0] = a_r.ray_dir_x;
    dir_c[1] = a_r.ray_dir_y;
    dir_c[2] = a_r.ray_dir_z;
    lo_c[0] = {a_r.box_origin_x[COORD_W-1], a_r.box_origin_x};
    hi_c[0] = lo_c[0] + {2'b00, a_r.box_width};
    lo_c[1] = {a_r.box_origin_y[COORD_W-1], a_r.box_origin_y};
    hi_c[1] = lo_c[1] + {2'b00, a_r.box_height};
    hi_c[2] = {a_r.box_origin_z[COORD_W-1], a_r.box_origin_z};
    lo_c[2] = hi_c[2] - {2'b00, a_r.box_depth};
    for (int i = 0; i < 3; i++) begin
      cmag_c[i] = dir_c[i][COORD_W-1] ? DEN_W'(-dir_c[i]) : DEN_W'(dir_c[i]);
      s1_side_nxt.dneg[i] = dir_c[i][COORD_W-1];
      s1_side_nxt.dmag[i] = cmag_c[i];
      s1_side_nxt.org[i]  = org_c[i];
      s1_side_nxt.lo[i]   = lo_c[i];
      s1_side_nxt.hi[i]   = hi_c[i];
    end
    for (int f = 0; f < NF; f++) begin
      ax    = face_axis(FACE_W'(f));
      plane = face_on_hi(FACE_W'(f)) ? hi_c[ax] : lo_c[ax];
      num   = {plane[BND_W-1], plane} - {{2{org_c[ax][COORD_W-1]}}, org_c[ax]};
      nmag  = num[NUM_W-1] ? -num : num;
      s1_dvd_nxt[f]       = {nmag[MAG_W-1:0], {FRAC_W{1'b0}}};
      s1_den_nxt[f]       = cmag_c[ax];
      s1_side_nxt.tneg[f] = num[NUM_W-1] ^ dir_c[ax][COORD_W-1];
      s1_side_nxt.ok[f]   = (cmag_c[ax] != '0) &&
                            (cmag_c[ax] >= {{(DEN_W-EPS_W){1'b0}}, eps_r});
    end
  end

  for (genvar f = 0; f < NF; f++) begin : g_div
    rbf_div #(
      .DVD_BITS(DVD_W),
      .DEN_BITS(DEN_W)
    ) u_div (
      .clk      (clk),
      .dividend (s1_dvd_r[f]),
      .divisor  (s1_den_r[f]),
      .quotient (quot[f])
    );
  end

  // Distance check, partial products, product sum, far clamp, point sum and in-face candidate test.
  side_t                                      s2_side_nxt;
  logic [NF-1:0][2:0][TSPLIT+DEN_W-1:0]       m1_lo_nxt;
  logic [NF-1:0][2:0][DVD_W-TSPLIT+DEN_W-1:0] m1_hi_nxt;
  logic [NF-1:0][2:0][PROD_W-1:0]             m2_prod_nxt;
  logic [NF-1:0][2:0][R_W-1:0]                m3_mag_nxt;
  logic [NF-1:0][2:0][PT_W-1:0]               m4_pt_nxt;
  cand_t                                      m5_cand_nxt [NF];

  always_comb begin
    logic            far;
    logic [PT_W-1:0] ext;
    logic [PT_W-1:0] sv;
    logic [1:0]      ax;
    logic            ins;
    logic [PT_W-1:0] lo_e;
    logic [PT_W-1:0] hi_e;
    s2_side_nxt = dl_side_r[DVD_W-1];
    for (int f = 0; f < NF; f++) begin
      s2_side_nxt.ok[f] = dl_side_r[DVD_W-1].ok[f] &&
                          (quot[f] > {{(DVD_W-EPS_W){1'b0}}, eps_r});
      for (int i = 0; i < 3; i++) begin
        m1_lo_nxt[f][i] = s2_tmag_r[f][TSPLIT-1:0] * s2_side_r.dmag[i];
        m1_hi_nxt[f][i] = s2_tmag_r[f][DVD_W-1:TSPLIT] * s2_side_r.dmag[i];
        m2_prod_nxt[f][i] = {m1_hi_r[f][i], {TSPLIT{1'b0}}} + m1_lo_r[f][i];
        far = ({1'b0, m2_prod_r[f][i]} +
               {{(PROD_W+1-DEN_W){1'b0}}, m2_side_r.dmag[i]}) > PROD_LIMIT;
        m3_mag_nxt[f][i] = far ? FAR_R : m2_prod_r[f][i][FRAC_W+R_W-1:FRAC_W];
        ext = {{(PT_W-R_W){1'b0}}, m3_mag_r[f][i]};
        sv  = (m3_side_r.tneg[f] ^ m3_side_r.dneg[i]) ? -ext : ext;
        m4_pt_nxt[f][i] = {{(PT_W-COORD_W){m3_side_r.org[i][COORD_W-1]}},
                           m3_side_r.org[i]} + sv;
      end
      ax  = face_axis(FACE_W'(f));
      ins = 1'b1;
      for (int j = 0; j < 3; j++) begin
        lo_e = {{(PT_W-BND_W){m4_side_r.lo[j][BND_W-1]}}, m4_side_r.lo[j]};
        hi_e = {{(PT_W-BND_W){m4_side_r.hi[j][BND_W-1]}}, m4_side_r.hi[j]};
        if (j != int'(ax)) begin
          ins = ins && ($signed(lo_e) < $signed(m4_pt_r[f][j])) &&
                ($signed(m4_pt_r[f][j]) < $signed(hi_e));
        end
      end
      m5_cand_nxt[f].ok   = m4_side_r.ok[f] && ins;
      m5_cand_nxt[f].face = FACE_W'(f);
      m5_cand_nxt[f].tmag = m4_tmag_r[f];
      m5_cand_nxt[f].pt   = m4_pt_r[f];
    end
  end

  out_t out_nxt;

  always_comb begin
    out_nxt.hit      = t3_cand_r.ok;
    out_nxt.hit_face = t3_cand_r.ok ? t3_cand_r.face : FACE_TOP;
    out_nxt.point_x  = t3_cand_r.ok ? sat(t3_cand_r.pt[0]) : '0;
    out_nxt.point_y  = t3_cand_r.ok ? sat(t3_cand_r.pt[1]) : '0;
    out_nxt.point_z  = t3_cand_r.ok ? sat(t3_cand_r.pt[2]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r     <= EPS_RESET;
      busy_r    <= 1'b1;
      a_vld_r   <= 1'b0;
      s1_vld_r  <= 1'b0;
      dl_vld_r  <= '0;
      s2_vld_r  <= 1'b0;
      m1_vld_r  <= 1'b0;
      m2_vld_r  <= 1'b0;
      m3_vld_r  <= 1'b0;
      m4_vld_r  <= 1'b0;
      m5_vld_r  <= 1'b0;
      t1_vld_r  <= 1'b0;
      t2_vld_r  <= 1'b0;
      t3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end
      busy_r    <= 1'b0;
      a_vld_r   <= start && !busy_r;
      s1_vld_r  <= a_vld_r;
      dl_vld_r  <= {dl_vld_r[DVD_W-2:0], s1_vld_r};
      s2_vld_r  <= dl_vld_r[DVD_W-1];
      m1_vld_r  <= s2_vld_r;
      m2_vld_r  <= m1_vld_r;
      m3_vld_r  <= m2_vld_r;
      m4_vld_r  <= m3_vld_r;
      m5_vld_r  <= m4_vld_r;
      t1_vld_r  <= m5_vld_r;
      t2_vld_r  <= t1_vld_r;
      t3_vld_r  <= t2_vld_r;
      out_vld_r <= t3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= in_data;
    s1_side_r    <= s1_side_nxt;
    s1_dvd_r     <= s1_dvd_nxt;
    s1_den_r     <= s1_den_nxt;
    dl_side_r[0] <= s1_side_r;
    for (int k = 1; k < DVD_W; k++) begin
      dl_side_r[k] <= dl_side_r[k-1];
    end
    s2_side_r <= s2_side_nxt;
    s2_tmag_r <= quot;
    m1_side_r <= s2_side_r;
    m1_tmag_r <= s2_tmag_r;
    m1_lo_r   <= m1_lo_nxt;
    m1_hi_r   <= m1_hi_nxt;
    m2_side_r <= m1_side_r;
    m2_tmag_r <= m1_tmag_r;
    m2_prod_r <= m2_prod_nxt;
    m3_side_r <= m2_side_r;
    m3_tmag_r <= m2_tmag_r;
    m3_mag_r  <= m3_mag_nxt;
    m4_side_r <= m3_side_r;
    m4_tmag_r <= m3_tmag_r;
    m4_pt_r   <= m4_pt_nxt;
    for (int f = 0; f < NF; f++) begin
      m5_cand_r[f] <= m5_cand_nxt[f];
    end
    t1_cand_r[0] <= pick(m5_cand_r[0], m5_cand_r[1]);
    t1_cand_r[1] <= pick(m5_cand_r[2], m5_cand_r[3]);
    t1_cand_r[2] <= m5_cand_r[4];
    t2_cand_r[0] <= pick(t1_cand_r[0], t1_cand_r[1]);
    t2_cand_r[1] <= t1_cand_r[2];
    t3_cand_r    <= pick(t2_cand_r[0], t2_cand_r[1]);
    out_r        <= out_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// File: design/rbf_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Accepts a new operand pair every cycle; the quotient is taken from the last stage register.
// Depends on rbf_pkg for default widths.
module rbf_div import rbf_pkg::*; #(
  parameter int DVD_BITS = DVD_W,
  parameter int DEN_BITS = DEN_W
) (
  input  logic                clk,
  input  logic [DVD_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0] divisor,
  output logic [DVD_BITS-1:0] quotient
);

  logic [DEN_BITS-1:0] rem_r [DVD_BITS];
  logic [DVD_BITS-1:0] dvd_r [DVD_BITS];
  logic [DEN_BITS-1:0] den_r [DVD_BITS];

  for (genvar k = 0; k < DVD_BITS; k++) begin : g_stage
    logic [DEN_BITS-1:0] rem_in;
    logic [DVD_BITS-1:0] dvd_in;
    logic [DEN_BITS-1:0] den_in;
    logic [DEN_BITS:0]   sh;
    logic [DEN_BITS:0]   diff;
    logic                ge;
    logic [DEN_BITS-1:0] rem_nxt;
    logic [DVD_BITS-1:0] dvd_nxt;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = dividend;
      assign den_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dvd_in = dvd_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign sh      = {rem_in, dvd_in[DVD_BITS-1]};
    assign diff    = sh - {1'b0, den_in};
    assign ge      = sh >= {1'b0, den_in};
    assign rem_nxt = ge ? diff[DEN_BITS-1:0] : sh[DEN_BITS-1:0];
    assign dvd_nxt = {dvd_in[DVD_BITS-2:0], ge};

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      dvd_r[k] <= dvd_nxt;
      den_r[k] <= den_in;
    end
  end

  assign quotient = dvd_r[DVD_BITS-1];

endmodule
